>>> rtl/rau_pkg.sv
// Shared constants, types and helper functions of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

  localparam int WORD_BITS    = 32;
  localparam int MAX_EXPONENT = 31;
  localparam int NUM_W        = 32;
  localparam int DEN_W        = 31;
  localparam int ACT_W        = 3;
  localparam int EXP_W        = 6;
  localparam int EXT_W        = 64;
  localparam int MUL_STEPS    = 32;
  localparam int DIV_STEPS    = 64;
  localparam int CNT_W        = 7;

  localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CMP   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_POW   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPLIT = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NORM  = 3'd7;

  localparam logic [EXT_W-1:0] MAX_POS = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  // sign-magnitude fraction at extended width
  typedef struct packed {
    logic             neg;
    logic [EXT_W-1:0] mag;
    logic [EXT_W-1:0] den;
  } frac_t;

  // request to the serial multiply / divide unit
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [EXT_W-1:0] opa;
    logic [EXT_W-1:0] opb;
  } md_req_t;

  // acc holds product or remainder, shq holds quotient
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [EXT_W-1:0] acc;
    logic [EXT_W-1:0] shq;
  } md_rsp_t;

  function automatic frac_t make_operand(input logic [NUM_W-1:0] n,
                                         input logic [NUM_W-1:0] d);
    frac_t            f;
    logic [NUM_W-1:0] nm;
    logic [NUM_W-1:0] dm;
    nm = n[NUM_W-1] ? (~n + 32'd1) : n;
    dm = d[NUM_W-1] ? (~d + 32'd1) : d;
    if (d == '0) begin
      dm = 32'd1;
    end
    f.neg = n[NUM_W-1] ^ d[NUM_W-1];
    f.mag = {32'b0, nm};
    f.den = {32'b0, dm};
    return f;
  endfunction

  function automatic logic num_fits(input logic neg, input logic [EXT_W-1:0] mag);
    return neg ? (mag <= MAX_POS + 64'd1) : (mag <= MAX_POS);
  endfunction

  // keep the low WORD_BITS bits of a signed value, sign-extended to NUM_W
  function automatic logic [NUM_W-1:0] pack_signed(input logic neg,
                                                   input logic [EXT_W-1:0] mag);
    logic        [EXT_W-1:0] v;
    logic signed [EXT_W-1:0] s;
    v = neg ? (~mag + 64'd1) : mag;
    s = $signed(v << (EXT_W - WORD_BITS)) >>> (EXT_W - WORD_BITS);
    return s[NUM_W-1:0];
  endfunction

endpackage

>>> rtl/rau_if.sv
// Handshake channel interfaces for operands in and results out.
`timescale 1ns / 1ps
interface rau_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [rau_pkg::ACT_W-1:0]         action;
  logic signed [rau_pkg::NUM_W-1:0]         a_num;
  logic signed [rau_pkg::NUM_W-1:0]         a_den;
  logic signed [rau_pkg::NUM_W-1:0]         b_num;
  logic signed [rau_pkg::NUM_W-1:0]         b_den;
  logic signed [rau_pkg::EXP_W-1:0]         exponent;

  modport source (output valid, action, a_num, a_den, b_num, b_den, exponent,
                  input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, exponent,
                  output ready);
endinterface

interface rau_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rau_pkg::NUM_W-1:0] res_num;
  logic        [rau_pkg::DEN_W-1:0] res_den;
  logic signed [rau_pkg::NUM_W-1:0] whole_part;
  logic                             is_less;
  logic                             is_equal;
  logic                             is_greater;
  logic                             is_integer;
  logic                             divide_by_zero;
  logic                             zero_denominator;
  logic                             overflow;

  modport source (output valid, res_num, res_den, whole_part, is_less, is_equal,
                  is_greater, is_integer, divide_by_zero, zero_denominator,
                  overflow, input ready);
  modport sink   (input valid, res_num, res_den, whole_part, is_less, is_equal,
                  is_greater, is_integer, divide_by_zero, zero_denominator,
                  overflow, output ready);
endinterface

>>> rtl/rational_arithmetic_unit.sv
// Top level: rational ALU sequencer around one shared serial multiply/divide unit.
//
//   channel  dir  handshake         beat contents
//   req_i    in   valid / ready     action, a_num, a_den, b_num, b_den, exponent
//   rsp_o    out  valid / ready     res_num, res_den, whole_part, flags
//
// One beat at a time: req_i.ready is high only while the sequencer is idle.
// Every quotient, remainder and product is computed in the shared serial unit; one
// reduction costs one division per Euclid step plus two more for the quotients.
// Normalize of small values is the shortest item and add or subtract with long
// Euclid chains the longest; power with exponent 31 issues its 62 products.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled result holds in the output register while the next beat is taken.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
  input logic         clk_i,
  input logic         rst_ni,
  rau_in_if.sink      req_i,
  rau_out_if.source   rsp_o
);
  import rau_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RED     = 4'd1;
  localparam logic [3:0] ST_GCD     = 4'd2;
  localparam logic [3:0] ST_GCD_W   = 4'd3;
  localparam logic [3:0] ST_QM_W    = 4'd4;
  localparam logic [3:0] ST_QD_W    = 4'd5;
  localparam logic [3:0] ST_RED_END = 4'd6;
  localparam logic [3:0] ST_DISP    = 4'd7;
  localparam logic [3:0] ST_MUL     = 4'd8;
  localparam logic [3:0] ST_MUL_W   = 4'd9;
  localparam logic [3:0] ST_COMB    = 4'd10;
  localparam logic [3:0] ST_POW     = 4'd11;
  localparam logic [3:0] ST_POW_W   = 4'd12;
  localparam logic [3:0] ST_SPL_W   = 4'd13;
  localparam logic [3:0] ST_FIN     = 4'd14;

  // which fraction the running reduction belongs to
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  localparam frac_t FRAC_ZERO = '{neg: 1'b0, mag: 64'd0, den: 64'd1};
  localparam frac_t FRAC_ONE  = '{neg: 1'b0, mag: 64'd1, den: 64'd1};

  logic [3:0]       state_q;
  logic [1:0]       phase_q;
  logic [1:0]       mi_q;
  logic             pass_q;
  logic [EXP_W-1:0] pcnt_q;
  logic             out_valid_q;

  logic [ACT_W-1:0] act_q;
  logic [EXP_W-1:0] k_q;
  logic             eneg_q;
  logic [NUM_W-1:0] bn_raw_q;
  logic [NUM_W-1:0] bd_raw_q;
  frac_t            w_q;
  logic [EXT_W-1:0] gx_q;
  logic [EXT_W-1:0] gy_q;
  logic             a_neg_q;
  logic [NUM_W-1:0] a_mag_q;
  logic [NUM_W-1:0] a_den_q;
  logic             b_neg_q;
  logic [NUM_W-1:0] b_mag_q;
  logic [NUM_W-1:0] b_den_q;
  logic [EXT_W-1:0] p0_q;
  logic [EXT_W-1:0] p1_q;
  logic [EXT_W-1:0] p2_q;
  logic             pcap_q;
  logic [NUM_W-1:0] plo_q;
  logic             ncap_q;
  logic [NUM_W-1:0] nlo_q;
  logic             whole_neg_q;
  logic [NUM_W-1:0] whole_mag_q;
  logic             zden_q;
  logic             dz_q;
  logic             lt_q;
  logic             eq_q;
  logic             gt_q;

  logic [NUM_W-1:0] o_num_q;
  logic [DEN_W-1:0] o_den_q;
  logic [NUM_W-1:0] o_whole_q;
  logic             o_lt_q;
  logic             o_eq_q;
  logic             o_gt_q;
  logic             o_int_q;
  logic             o_dz_q;
  logic             o_zden_q;
  logic             o_ovf_q;

  md_req_t          md_req;
  md_rsp_t          md_rsp;

  logic             in_fire;
  logic             out_fire;
  logic             fin_go;
  logic [EXP_W-1:0] kraw;
  logic [EXP_W-1:0] kcalc;
  logic [NUM_W-1:0] mul_a;
  logic [NUM_W-1:0] mul_b;
  logic             mul_last;
  logic [NUM_W-1:0] pow_base;
  logic             n2;
  logic             sm_neg;
  logic [EXT_W-1:0] sm_mag;
  logic             prod_hi;
  logic [EXT_W-1:0] den_m;
  logic             ovf;

  rau_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_fire    = out_valid_q && rsp_o.ready;
  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || rsp_o.ready);

  // exponent magnitude, the most negative pattern saturates
  assign kraw  = req_i.exponent[EXP_W-1] ? (~req_i.exponent + 1'b1) : req_i.exponent;
  assign kcalc = (kraw > EXP_W'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT) : kraw;

  // multiply operands per action and slot
  always_comb begin
    mul_a = a_den_q;
    mul_b = b_den_q;
    case (mi_q)
      2'd0: begin
        mul_a = a_mag_q;
        mul_b = (act_q == ACT_MUL) ? b_mag_q : b_den_q;
      end
      2'd1: begin
        if (act_q == ACT_MUL) begin
          mul_a = a_den_q;
          mul_b = b_den_q;
        end else if (act_q == ACT_DIV) begin
          mul_a = a_den_q;
          mul_b = b_mag_q;
        end else begin
          mul_a = b_mag_q;
          mul_b = a_den_q;
        end
      end
      default: begin
        mul_a = a_den_q;
        mul_b = b_den_q;
      end
    endcase
  end

  assign mul_last = (mi_q == 2'd2) ||
                    ((mi_q == 2'd1) && !(act_q inside {ACT_ADD, ACT_SUB}));

  // base of the current power pass; a zero base with negative exponent uses 1
  always_comb begin
    if (!pass_q) begin
      pow_base = eneg_q ? a_den_q : a_mag_q;
    end else if (eneg_q) begin
      pow_base = (a_mag_q == '0) ? 32'd1 : a_mag_q;
    end else begin
      pow_base = a_den_q;
    end
  end

  // signed sum of the two cross products
  always_comb begin
    n2 = (act_q == ACT_ADD) ? b_neg_q : !b_neg_q;
    if (a_neg_q == n2) begin
      sm_neg = a_neg_q;
      sm_mag = p0_q + p1_q;
    end else if (p0_q >= p1_q) begin
      sm_neg = a_neg_q;
      sm_mag = p0_q - p1_q;
    end else begin
      sm_neg = n2;
      sm_mag = p1_q - p0_q;
    end
  end

  assign prod_hi = |md_rsp.acc[EXT_W-1:NUM_W];
  assign den_m   = w_q.den & MAX_POS;
  assign ovf     = !num_fits(w_q.neg, w_q.mag) || (w_q.den > MAX_POS) ||
                   !num_fits(whole_neg_q, {32'b0, whole_mag_q});

  // issue work to the shared unit
  always_comb begin
    md_req = '0;
    case (state_q)
      ST_GCD: begin
        md_req.start  = 1'b1;
        md_req.is_div = 1'b1;
        md_req.opa    = (gy_q == '0) ? w_q.mag : gx_q;
        md_req.opb    = (gy_q == '0) ? gx_q : gy_q;
      end
      ST_QM_W: begin
        md_req.start  = md_rsp.done;
        md_req.is_div = 1'b1;
        md_req.opa    = w_q.den;
        md_req.opb    = gx_q;
      end
      ST_DISP: begin
        md_req.start  = (act_q == ACT_SPLIT);
        md_req.is_div = 1'b1;
        md_req.opa    = {32'b0, a_mag_q};
        md_req.opb    = {32'b0, a_den_q};
      end
      ST_MUL: begin
        md_req.start  = 1'b1;
        md_req.opa    = {32'b0, mul_a};
        md_req.opb    = {32'b0, mul_b};
      end
      ST_POW: begin
        md_req.start  = 1'b1;
        md_req.opa    = {32'b0, plo_q};
        md_req.opb    = {32'b0, pow_base};
      end
      default: ;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_A;
      mi_q        <= '0;
      pass_q      <= 1'b0;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            phase_q <= PH_A;
            state_q <= ST_RED;
          end
        end
        ST_RED: state_q <= ST_GCD;
        ST_GCD: state_q <= (gy_q == '0) ? ST_QM_W : ST_GCD_W;
        ST_GCD_W: begin
          if (md_rsp.done) state_q <= ST_GCD;
        end
        ST_QM_W: begin
          if (md_rsp.done) state_q <= ST_QD_W;
        end
        ST_QD_W: begin
          if (md_rsp.done) state_q <= ST_RED_END;
        end
        ST_RED_END: begin
          case (phase_q)
            PH_A: begin
              if (act_q inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_CMP}) begin
                phase_q <= PH_B;
                state_q <= ST_RED;
              end else begin
                state_q <= ST_DISP;
              end
            end
            PH_B:    state_q <= ST_DISP;
            default: state_q <= ST_FIN;
          endcase
        end
        ST_DISP: begin
          case (act_q)
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_CMP: begin
              mi_q    <= '0;
              state_q <= ST_MUL;
            end
            ACT_DIV: begin
              mi_q    <= '0;
              state_q <= (b_mag_q == '0) ? ST_FIN : ST_MUL;
            end
            ACT_POW: begin
              pass_q  <= 1'b0;
              pcnt_q  <= k_q;
              state_q <= (k_q == '0) ? ST_FIN : ST_POW;
            end
            ACT_SPLIT: state_q <= ST_SPL_W;
            default:   state_q <= ST_FIN;
          endcase
        end
        ST_MUL: state_q <= ST_MUL_W;
        ST_MUL_W: begin
          if (md_rsp.done) begin
            if (mul_last) begin
              state_q <= ST_COMB;
            end else begin
              mi_q    <= mi_q + 1'b1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_COMB: begin
          if (act_q == ACT_CMP) begin
            state_q <= ST_FIN;
          end else begin
            phase_q <= PH_R;
            state_q <= ST_RED;
          end
        end
        ST_POW: state_q <= ST_POW_W;
        ST_POW_W: begin
          if (md_rsp.done) begin
            if (pcnt_q == EXP_W'(1)) begin
              if (!pass_q) begin
                pass_q  <= 1'b1;
                pcnt_q  <= k_q;
                state_q <= ST_POW;
              end else begin
                state_q <= ST_FIN;
              end
            end else begin
              pcnt_q  <= pcnt_q - 1'b1;
              state_q <= ST_POW;
            end
          end
        end
        ST_SPL_W: begin
          if (md_rsp.done) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_q       <= req_i.action;
          k_q         <= kcalc;
          eneg_q      <= req_i.exponent[EXP_W-1];
          bn_raw_q    <= req_i.b_num;
          bd_raw_q    <= req_i.b_den;
          w_q         <= make_operand(req_i.a_num, req_i.a_den);
          zden_q      <= (req_i.a_den == '0) ||
                         ((req_i.action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV,
                                                ACT_CMP}) && (req_i.b_den == '0));
          dz_q        <= 1'b0;
          lt_q        <= 1'b0;
          eq_q        <= 1'b0;
          gt_q        <= 1'b0;
          whole_neg_q <= 1'b0;
          whole_mag_q <= '0;
        end
      end
      ST_RED: begin
        gx_q <= w_q.mag;
        gy_q <= w_q.den;
      end
      ST_GCD_W: begin
        if (md_rsp.done) begin
          gx_q <= gy_q;
          gy_q <= md_rsp.acc;
        end
      end
      ST_QM_W: begin
        if (md_rsp.done) w_q.mag <= md_rsp.shq;
      end
      ST_QD_W: begin
        if (md_rsp.done) begin
          w_q.den <= md_rsp.shq;
          if (w_q.mag == '0) w_q.neg <= 1'b0;
        end
      end
      ST_RED_END: begin
        if (phase_q == PH_A) begin
          a_neg_q <= w_q.neg;
          a_mag_q <= w_q.mag[NUM_W-1:0];
          a_den_q <= w_q.den[NUM_W-1:0];
          if (act_q inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_CMP}) begin
            w_q <= make_operand(bn_raw_q, bd_raw_q);
          end
        end else if (phase_q == PH_B) begin
          b_neg_q <= w_q.neg;
          b_mag_q <= w_q.mag[NUM_W-1:0];
          b_den_q <= w_q.den[NUM_W-1:0];
        end
      end
      ST_DISP: begin
        if ((act_q == ACT_DIV) && (b_mag_q == '0)) begin
          dz_q <= 1'b1;
          w_q  <= FRAC_ZERO;
        end else if (act_q == ACT_POW) begin
          if (k_q == '0) begin
            w_q <= FRAC_ONE;
          end else begin
            pcap_q <= 1'b0;
            plo_q  <= 32'd1;
            if (eneg_q && (a_mag_q == '0)) zden_q <= 1'b1;
          end
        end
      end
      ST_MUL_W: begin
        if (md_rsp.done) begin
          case (mi_q)
            2'd0:    p0_q <= md_rsp.acc;
            2'd1:    p1_q <= md_rsp.acc;
            default: p2_q <= md_rsp.acc;
          endcase
        end
      end
      ST_COMB: begin
        case (act_q)
          ACT_MUL, ACT_DIV: begin
            w_q.neg <= a_neg_q ^ b_neg_q;
            w_q.mag <= p0_q;
            w_q.den <= p1_q;
          end
          ACT_ADD, ACT_SUB: begin
            w_q.neg <= sm_neg;
            w_q.mag <= sm_mag;
            w_q.den <= p2_q;
          end
          default: begin
            eq_q <= (a_neg_q == b_neg_q) && (a_mag_q == b_mag_q) &&
                    (a_den_q == b_den_q);
            lt_q <= (sm_mag != '0) && sm_neg;
            gt_q <= (sm_mag != '0) && !sm_neg;
            w_q  <= FRAC_ZERO;
          end
        endcase
      end
      ST_POW_W: begin
        if (md_rsp.done) begin
          if ((pcnt_q == EXP_W'(1)) && !pass_q) begin
            ncap_q <= pcap_q | prod_hi;
            nlo_q  <= md_rsp.acc[NUM_W-1:0];
            pcap_q <= 1'b0;
            plo_q  <= 32'd1;
          end else if (pcnt_q == EXP_W'(1)) begin
            // saturated parts read above range, so the fit check flags them
            w_q.neg <= a_neg_q & k_q[0];
            w_q.mag <= {31'b0, ncap_q, nlo_q};
            w_q.den <= {31'b0, pcap_q | prod_hi, md_rsp.acc[NUM_W-1:0]};
          end else begin
            pcap_q <= pcap_q | prod_hi;
            plo_q  <= md_rsp.acc[NUM_W-1:0];
          end
        end
      end
      ST_SPL_W: begin
        if (md_rsp.done) begin
          whole_neg_q <= a_neg_q;
          whole_mag_q <= md_rsp.shq[NUM_W-1:0];
          if (md_rsp.acc != '0) begin
            w_q.neg <= a_neg_q;
            w_q.mag <= md_rsp.acc;
            w_q.den <= {32'b0, a_den_q};
          end else begin
            w_q <= FRAC_ZERO;
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          o_num_q   <= pack_signed(w_q.neg, w_q.mag);
          o_den_q   <= den_m[DEN_W-1:0];
          o_whole_q <= pack_signed(whole_neg_q, {32'b0, whole_mag_q});
          o_lt_q    <= lt_q;
          o_eq_q    <= eq_q;
          o_gt_q    <= gt_q;
          o_int_q   <= (w_q.den == 64'd1);
          o_dz_q    <= dz_q;
          o_zden_q  <= zden_q;
          o_ovf_q   <= ovf;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.res_num          = o_num_q;
  assign rsp_o.res_den          = o_den_q;
  assign rsp_o.whole_part       = o_whole_q;
  assign rsp_o.is_less          = o_lt_q;
  assign rsp_o.is_equal         = o_eq_q;
  assign rsp_o.is_greater       = o_gt_q;
  assign rsp_o.is_integer       = o_int_q;
  assign rsp_o.divide_by_zero   = o_dz_q;
  assign rsp_o.zero_denominator = o_zden_q;
  assign rsp_o.overflow         = o_ovf_q;

`ifndef SYNTHESIS
  // the shared unit only gets work while it is free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_rsp.busy)
    else $error("shared unit started while busy");

  // a result beat appears only out of the final state
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result valid without finishing an item");

  // at most one compare outcome per result
  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({o_lt_q, o_eq_q, o_gt_q}))
    else $error("compare flags not exclusive");

  // a zero denominator can only leave the block flagged as overflow
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((o_den_q != '0) || o_ovf_q))
    else $error("zero denominator without overflow");
`endif

endmodule

>>> rtl/rau_muldiv.sv
// Shared serial unit: shift-add multiply and restoring divide, one bit per cycle.
`timescale 1ns / 1ps
module rau_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::md_req_t  req_i,
  output rau_pkg::md_rsp_t  rsp_o
);
  import rau_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             div_q;
  logic [EXT_W-1:0] acc_q;
  logic [EXT_W-1:0] sh_q;
  logic [EXT_W-1:0] opb_q;
  logic [EXT_W:0]   rem_sh;
  logic [EXT_W+1:0] diff;

  assign rem_sh = {acc_q, sh_q[EXT_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, opb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          cnt_q  <= req_i.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
        end
      end else begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        div_q <= req_i.is_div;
        acc_q <= '0;
        sh_q  <= req_i.opa;
        opb_q <= req_i.opb;
      end
    end else if (div_q) begin
      if (!diff[EXT_W+1]) begin
        acc_q <= diff[EXT_W-1:0];
        sh_q  <= {sh_q[EXT_W-2:0], 1'b1};
      end else begin
        acc_q <= rem_sh[EXT_W-1:0];
        sh_q  <= {sh_q[EXT_W-2:0], 1'b0};
      end
    end else begin
      if (opb_q[0]) begin
        acc_q <= acc_q + sh_q;
      end
      sh_q  <= sh_q << 1;
      opb_q <= opb_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.shq  = sh_q;

endmodule

>>> sim/tb_rational_arithmetic_unit.sv
// Self-checking testbench of the rational arithmetic unit: table of directed beats, then random.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  // Generous bound on the whole run, covering the longest items plus stalls on both sides.
  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int          RANDOM_BEATS = 830;

  typedef struct {
    logic             neg;
    logic [EXT_W-1:0] mag;
    logic [EXT_W-1:0] den;
  } ratio_t;

  typedef struct packed {
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic [NUM_W-1:0] whole_part;
    logic             is_less;
    logic             is_equal;
    logic             is_greater;
    logic             is_integer;
    logic             divide_by_zero;
    logic             zero_denominator;
    logic             overflow;
  } outcome_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [NUM_W-1:0] a_num;
    logic [NUM_W-1:0] a_den;
    logic [NUM_W-1:0] b_num;
    logic [NUM_W-1:0] b_den;
    logic [EXP_W-1:0] exponent;
  } operands_t;

  typedef struct {
    operands_t ops;
    logic      typed;
    outcome_t  want;
  } row_t;

  logic clk;
  logic rst_n;
  int unsigned cycles;
  int unsigned mismatches;

  rau_in_if  req ();
  rau_out_if rsp ();

  rational_arithmetic_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  outcome_t pending_q[$];
  row_t     rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact sign-magnitude arithmetic at 64 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [EXT_W-1:0] euclid(logic [EXT_W-1:0] x, logic [EXT_W-1:0] y);
    logic [EXT_W-1:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic ratio_t lowest_terms(ratio_t f);
    logic [EXT_W-1:0] g;
    if (f.den == 0) f.den = 1;
    g = euclid(f.mag, f.den);
    if (g == 0) g = 1;
    f.mag = f.mag / g;
    f.den = f.den / g;
    if (f.mag == 0) f.neg = 1'b0;
    return f;
  endfunction

  // Move the denominator's sign up, replace a zero denominator, reduce.
  function automatic ratio_t load_operand(logic [NUM_W-1:0] n, logic [NUM_W-1:0] d,
                                          inout logic zden);
    logic signed [EXT_W-1:0] sn;
    logic signed [EXT_W-1:0] sd;
    ratio_t f;
    sn = $signed(n);
    sd = $signed(d);
    if (sd == 0) begin
      sd = 1;
      zden = 1'b1;
    end
    f.neg = sn < 0;
    f.mag = f.neg ? -sn : sn;
    if (sd < 0) begin
      f.neg = !f.neg;
      f.den = -sd;
    end else begin
      f.den = sd;
    end
    return lowest_terms(f);
  endfunction

  function automatic ratio_t signed_sum(logic n1, logic [EXT_W-1:0] m1,
                                        logic n2, logic [EXT_W-1:0] m2);
    ratio_t r;
    r.den = 1;
    if (n1 == n2) begin
      r.neg = n1;
      r.mag = m1 + m2;
    end else if (m1 >= m2) begin
      r.neg = n1;
      r.mag = m1 - m2;
    end else begin
      r.neg = n2;
      r.mag = m2 - m1;
    end
    return r;
  endfunction

  function automatic logic fits_word(logic neg, logic [EXT_W-1:0] mag);
    return neg ? (mag <= MAX_POS + 64'd1) : (mag <= MAX_POS);
  endfunction

  // Power with wrapped low bits in low; returned magnitude saturates at 2^32.
  function automatic logic [EXT_W-1:0] capped_power(logic [EXT_W-1:0] base, int k,
                                                    output logic [EXT_W-1:0] low);
    logic [EXT_W-1:0] sat;
    sat = 1;
    low = 1;
    for (int i = 0; i < k; i++) begin
      low = low * base;
      sat = sat * base;
      if (sat > 64'h1_0000_0000) sat = 64'h1_0000_0000;
    end
    return sat;
  endfunction

  function automatic outcome_t rational_result(operands_t q);
    outcome_t         o;
    ratio_t           a;
    ratio_t           b;
    ratio_t           r;
    ratio_t           d;
    logic             zden;
    logic             ovf;
    logic             whole_neg;
    logic [EXT_W-1:0] whole_mag;
    logic [EXT_W-1:0] sn, sd, ln, ld, rem, wrapped;
    logic             eneg;
    int               k;
    zden = 1'b0;
    ovf = 1'b0;
    whole_neg = 1'b0;
    whole_mag = 0;
    o = '0;
    a = load_operand(q.a_num, q.a_den, zden);
    // unary actions ignore b and its zero-denominator flag
    if (q.action <= ACT_CMP) b = load_operand(q.b_num, q.b_den, zden);
    else b = a;
    r.neg = 1'b0;
    r.mag = 0;
    r.den = 1;
    case (q.action)
      ACT_ADD, ACT_SUB: begin
        r = signed_sum(a.neg, a.mag * b.den,
                       (q.action == ACT_SUB) ? !b.neg : b.neg, b.mag * a.den);
        r.den = a.den * b.den;
        r = lowest_terms(r);
      end
      ACT_MUL: begin
        r.neg = a.neg != b.neg;
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
        r = lowest_terms(r);
      end
      ACT_DIV: begin
        if (b.mag == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          r.neg = a.neg != b.neg;
          r.mag = a.mag * b.den;
          r.den = a.den * b.mag;
          r = lowest_terms(r);
        end
      end
      ACT_CMP: begin
        d = signed_sum(a.neg, a.mag * b.den, !b.neg, b.mag * a.den);
        o.is_equal   = (a.neg == b.neg) && (a.mag == b.mag) && (a.den == b.den);
        o.is_less    = (d.mag != 0) && d.neg;
        o.is_greater = (d.mag != 0) && !d.neg;
      end
      ACT_POW: begin
        eneg = q.exponent[EXP_W-1];
        k = eneg ? (64 - q.exponent) : q.exponent;
        // the pattern -32 saturates to the largest exponent
        if (k > MAX_EXPONENT) k = MAX_EXPONENT;
        if (k == 0) begin
          r.mag = 1;
        end else begin
          r.neg = a.neg && k[0];
          if (!eneg) begin
            sn = capped_power(a.mag, k, ln);
            sd = capped_power(a.den, k, ld);
          end else if (a.mag == 0) begin
            // zero base with negative exponent: swapped denominator is zero
            zden = 1'b1;
            sn = capped_power(a.den, k, ln);
            sd = 1;
            ld = 1;
          end else begin
            sn = capped_power(a.den, k, ln);
            sd = capped_power(a.mag, k, ld);
          end
          r.mag = ln;
          r.den = ld;
          if (sn == 64'h1_0000_0000 || sd == 64'h1_0000_0000) ovf = 1'b1;
        end
      end
      ACT_SPLIT: begin
        rem = a.mag % a.den;
        whole_neg = a.neg;
        whole_mag = a.mag / a.den;
        if (!fits_word(whole_neg, whole_mag)) ovf = 1'b1;
        if (rem != 0) begin
          r.neg = a.neg;
          r.mag = rem;
          r.den = a.den;
        end
      end
      default: r = a;
    endcase
    if (!fits_word(r.neg, r.mag) || r.den > MAX_POS) ovf = 1'b1;
    wrapped = r.neg ? -r.mag : r.mag;
    o.res_num = wrapped[NUM_W-1:0];
    o.res_den = r.den[DEN_W-1:0];
    wrapped = whole_neg ? -whole_mag : whole_mag;
    o.whole_part = wrapped[NUM_W-1:0];
    o.is_integer = r.den == 1;
    o.zero_denominator = zden;
    o.overflow = ovf;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_row(logic [ACT_W-1:0] act, int an, int ad, int bn, int bd,
                         logic [EXP_W-1:0] e, logic typed, outcome_t want);
    row_t r;
    r.ops = '{act, an, ad, bn, bd, e};
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  // Mix of tiny, mid-size, full-width, extreme and power-of-two words.
  function automatic logic [NUM_W-1:0] pick_word();
    logic [NUM_W-1:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = $urandom_range(0, 40) - 20;
      4, 5:       w = {{16{1'b0}}, 16'($urandom)} - 32'd32768;
      6, 7:       w = $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7fff_ffff;
          2:       w = 32'hffff_ffff;
          3:       w = 32'd1;
          default: w = 32'd0;
        endcase
      end
      default: begin
        w = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) w = -w;
      end
    endcase
    return w;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(30, 120);
  endfunction

  // Present one beat and hold it until the unit takes it; record what it must produce.
  task automatic send_beat(operands_t ops, logic typed, outcome_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.action   <= ops.action;
    req.a_num    <= ops.a_num;
    req.a_den    <= ops.a_den;
    req.b_num    <= ops.b_num;
    req.b_den    <= ops.b_den;
    req.exponent <= ops.exponent;
    do @(posedge clk); while (!req.ready);
    pending_q.push_back(typed ? want : rational_result(ops));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and field-by-field compare.
  // ---------------------------------------------------------------------------
  initial begin
    int       stall;
    outcome_t exp_r;
    stall = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (pending_q.size() == 0) begin
          $error("result beat with no expectation pending");
          mismatches++;
        end else begin
          exp_r = pending_q.pop_front();
          if (rsp.res_num !== exp_r.res_num) begin
            $error("res_num: expected %h, got %h", exp_r.res_num, rsp.res_num);
            mismatches++;
          end
          if (rsp.res_den !== exp_r.res_den) begin
            $error("res_den: expected %h, got %h", exp_r.res_den, rsp.res_den);
            mismatches++;
          end
          if (rsp.whole_part !== exp_r.whole_part) begin
            $error("whole_part: expected %h, got %h", exp_r.whole_part, rsp.whole_part);
            mismatches++;
          end
          if (rsp.is_less !== exp_r.is_less) begin
            $error("is_less: expected %b, got %b", exp_r.is_less, rsp.is_less);
            mismatches++;
          end
          if (rsp.is_equal !== exp_r.is_equal) begin
            $error("is_equal: expected %b, got %b", exp_r.is_equal, rsp.is_equal);
            mismatches++;
          end
          if (rsp.is_greater !== exp_r.is_greater) begin
            $error("is_greater: expected %b, got %b", exp_r.is_greater, rsp.is_greater);
            mismatches++;
          end
          if (rsp.is_integer !== exp_r.is_integer) begin
            $error("is_integer: expected %b, got %b", exp_r.is_integer, rsp.is_integer);
            mismatches++;
          end
          if (rsp.divide_by_zero !== exp_r.divide_by_zero) begin
            $error("divide_by_zero: expected %b, got %b",
                   exp_r.divide_by_zero, rsp.divide_by_zero);
            mismatches++;
          end
          if (rsp.zero_denominator !== exp_r.zero_denominator) begin
            $error("zero_denominator: expected %b, got %b",
                   exp_r.zero_denominator, rsp.zero_denominator);
            mismatches++;
          end
          if (rsp.overflow !== exp_r.overflow) begin
            $error("overflow: expected %b, got %b", exp_r.overflow, rsp.overflow);
            mismatches++;
          end
        end
      end
      // Mostly ready; now and then drop it for a short or a long stretch.
      if (!rst_n) begin
        rsp.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 75) begin
        rsp.ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 4);
        rsp.ready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    operands_t ops;
    mismatches = 0;
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.action = ACT_ADD;
    req.a_num = '0;
    req.a_den = '0;
    req.b_num = '0;
    req.b_den = '0;
    req.exponent = '0;

    // Directed table; typed rows carry their answer, the rest go to the predictor.
    // fields: res_num, res_den, whole, lt, eq, gt, int, dz, zd, ovf
    add_row(ACT_ADD, 1, 2, 1, 3, 6'd0, 1'b1, '{5, 6, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row(ACT_SUB, 1, 2, 1, 2, 6'd0, 1'b1, '{0, 1, 0, 0, 0, 0, 1, 0, 0, 0});
    add_row(ACT_MUL, 32'h7fff_ffff, 1, 2, 1, 6'd0, 1'b1,
            '{-2, 1, 0, 0, 0, 0, 1, 0, 0, 1});
    add_row(ACT_DIV, 3, 4, 0, 5, 6'd0, 1'b1, '{0, 1, 0, 0, 0, 0, 1, 1, 0, 0});
    add_row(ACT_ADD, 1, 0, 1, 1, 6'd0, 1'b1, '{2, 1, 0, 0, 0, 0, 1, 0, 1, 0});
    add_row(ACT_NORM, 4, -8, 0, 0, 6'd0, 1'b1, '{-1, 2, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row(ACT_NORM, 0, 0, 0, 0, 6'd0, 1'b1, '{0, 1, 0, 0, 0, 0, 1, 0, 1, 0});
    add_row(ACT_CMP, 1, 2, 2, 4, 6'd0, 1'b1, '{0, 1, 0, 0, 1, 0, 1, 0, 0, 0});
    add_row(ACT_CMP, -1, 1, 1, 1, 6'd0, 1'b1, '{0, 1, 0, 1, 0, 0, 1, 0, 0, 0});
    add_row(ACT_CMP, 3, 1, 1, 1, 6'd0, 1'b1, '{0, 1, 0, 0, 0, 1, 1, 0, 0, 0});
    add_row(ACT_POW, 5, 7, 0, 0, 6'd0, 1'b1, '{1, 1, 0, 0, 0, 0, 1, 0, 0, 0});
    add_row(ACT_POW, 0, 1, 0, 0, 6'd0, 1'b1, '{1, 1, 0, 0, 0, 0, 1, 0, 0, 0});
    // zero base with a negative exponent: 0/3 reduces to 0/1, result 1/1 flagged
    add_row(ACT_POW, 0, 3, 0, 0, 6'b111110, 1'b1, '{1, 1, 0, 0, 0, 0, 1, 0, 1, 0});
    add_row(ACT_SPLIT, -7, 2, 0, 0, 6'd0, 1'b1, '{-1, 2, -3, 0, 0, 0, 0, 0, 0, 0});
    add_row(ACT_SPLIT, 32'h8000_0000, 1, 0, 0, 6'd0, 1'b1,
            '{0, 1, 32'h8000_0000, 0, 0, 0, 1, 0, 0, 0});
    add_row(ACT_SPLIT, 6, 3, 0, 0, 6'd0, 1'b1, '{0, 1, 2, 0, 0, 0, 1, 0, 0, 0});
    add_row(ACT_POW, 2, 1, 0, 0, 6'b100000, 1'b0, '0);
    add_row(ACT_POW, -3, 2, 0, 0, 6'd31, 1'b0, '0);
    add_row(ACT_POW, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 6'b100001, 1'b0, '0);
    add_row(ACT_NORM, 32'h8000_0000, -1, 0, 0, 6'd0, 1'b0, '0);
    add_row(ACT_DIV, 32'h8000_0000, 1, -1, 1, 6'd0, 1'b0, '0);
    add_row(ACT_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 6'd0, 1'b0, '0);
    add_row(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fffe,
            6'd0, 1'b0, '0);
    add_row(ACT_MUL, 32'h8000_0000, -3, 32'h8000_0000, 32'h8000_0000, 6'd0, 1'b0, '0);
    add_row(ACT_CMP, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_fffd,
            6'd0, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].ops, rows[i].typed, rows[i].want);

    // Hold off until the unit has drained every pending result.
    req.valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      ops.action   = ACT_W'($urandom_range(0, 7));
      ops.a_num    = pick_word();
      ops.a_den    = pick_word();
      ops.b_num    = pick_word();
      ops.b_den    = pick_word();
      ops.exponent = EXP_W'($urandom);
      send_beat(ops, 1'b0, '0);
    end
    req.valid <= 1'b0;

    do @(posedge clk); while (pending_q.size() != 0);
    repeat (50) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_muldiv.sv
rtl/rational_arithmetic_unit.sv
sim/tb_rational_arithmetic_unit.sv
